@@ sv/smi_pkg.sv @@
// smi_pkg: shared constants, status codes and cofactor index tables
// for the small matrix inverse block; no dependencies
`timescale 1ns / 1ps

package smi_pkg;

    // default element format, signed Q16.16
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // queue depths between front and back, and at the result side
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // supported shape codes on row_count / col_count
    localparam logic [1:0] SHAPE_2X2 = 2'd2;
    localparam logic [1:0] SHAPE_3X3 = 2'd3;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHAPE    = 2'd1,
        ST_SINGULAR = 2'd2
    } status_t;

    // cofactor k = a[P]*a[Q] - a[R]*a[S], element index is row*3 + col
    localparam int unsigned COF_P [9] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
    localparam int unsigned COF_Q [9] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
    localparam int unsigned COF_R [9] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
    localparam int unsigned COF_S [9] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

endpackage

@@ sv/smi_fifo.sv @@
// smi_fifo: small word queue with combinational head read
// depends on nothing but its parameters; DEPTH is a power of two
`timescale 1ns / 1ps

module smi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/smi_front.sv @@
// smi_front: accepts matrices, classifies the shape and forms the exact
// adjugate entries and determinant; uses smi_pkg
`timescale 1ns / 1ps

module smi_front import smi_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      push,
    output logic                                      full,
    input  logic [1:0]                                row_count,
    input  logic [1:0]                                col_count,
    input  logic [ELEM_WIDTH-1:0]                     elem [9],
    output logic                                      mid_push,
    input  logic                                      mid_full,
    output logic [2+9*(2*ELEM_WIDTH+1)+3*ELEM_WIDTH+2:0] mid_wdata
);

    localparam int W  = ELEM_WIDTH;
    localparam int NW = 2*W + 1;
    localparam int DW = 3*W + 3;
    localparam int TW = 3*W + 2;

    // stage valid bits
    logic [5:0] v_reg;
    logic       en;

    // stage 0: captured word
    logic [W-1:0]  a0_reg [9];
    status_t       st0_reg;
    logic          m0_reg;
    // stage 1: products
    logic [W-1:0]    a1_reg [9];
    logic [2*W-1:0]  pp_reg [9];
    logic [2*W-1:0]  pq_reg [9];
    status_t         st1_reg;
    logic            m1_reg;
    // stage 2: cofactors
    logic [W-1:0]    a2_reg [9];
    logic [NW-1:0]   cof2_reg [9];
    status_t         st2_reg;
    logic            m2_reg;
    // stage 3: determinant partial products
    logic [W-1:0]    a3_reg [9];
    logic [NW-1:0]   cof3_reg [9];
    logic [2*W:0]    plo_reg [3];
    logic [2*W:0]    phi_reg [3];
    status_t         st3_reg;
    logic            m3_reg;
    // stage 4: determinant terms and numerators
    logic [TW-1:0]   t4_reg [3];
    logic [NW-1:0]   num4_reg [9];
    status_t         st4_reg;
    logic            m4_reg;
    // stage 5: determinant sum
    logic [NW-1:0]   num5_reg [9];
    logic [DW-1:0]   det5_reg;
    status_t         st5_reg;

    logic    shape_ok;
    status_t st_in;

    // the whole front advances unless the last stage is held
    assign en       = ~(v_reg[5] & mid_full);
    assign full     = ~en;
    assign mid_push = v_reg[5] & ~mid_full;

    assign shape_ok = (row_count == col_count) &&
                      ((row_count == SHAPE_2X2) || (row_count == SHAPE_3X3));
    assign st_in    = shape_ok ? ST_OK : ST_SHAPE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], push};
        end
    end

    // stage 0 capture and control carry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg  <= elem;
            st0_reg <= st_in;
            m0_reg  <= (row_count == SHAPE_3X3);
            a1_reg  <= a0_reg;
            st1_reg <= st0_reg;
            m1_reg  <= m0_reg;
            a2_reg  <= a1_reg;
            st2_reg <= st1_reg;
            m2_reg  <= m1_reg;
            a3_reg  <= a2_reg;
            cof3_reg <= cof2_reg;
            st3_reg <= st2_reg;
            m3_reg  <= m2_reg;
            st4_reg <= st3_reg;
            m4_reg  <= m3_reg;
            num5_reg <= num4_reg;
            st5_reg <= st4_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < 9; k++)
        begin : g_cof
            // stage 1 products and stage 2 cofactor difference
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pp_reg[k]   <= (2*W)'($signed(a0_reg[COF_P[k]]) *
                                          $signed(a0_reg[COF_Q[k]]));
                    pq_reg[k]   <= (2*W)'($signed(a0_reg[COF_R[k]]) *
                                          $signed(a0_reg[COF_S[k]]));
                    cof2_reg[k] <= {pp_reg[k][2*W-1], pp_reg[k]} -
                                   {pq_reg[k][2*W-1], pq_reg[k]};
                end
            end
        end

        for (k = 0; k < 3; k++)
        begin : g_det
            logic [W:0] lo_ext;
            logic [W:0] hi_part;
            assign lo_ext  = {1'b0, cof2_reg[3*k][W-1:0]};
            assign hi_part = cof2_reg[3*k][2*W:W];

            // row 0 element times its cofactor, split at W bits
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    plo_reg[k] <= (2*W+1)'($signed(a2_reg[k]) * $signed(lo_ext));
                    phi_reg[k] <= (2*W+1)'($signed(a2_reg[k]) * $signed(hi_part));
                    t4_reg[k]  <= {phi_reg[k][2*W], phi_reg[k], {W{1'b0}}} +
                                  {{(W+1){plo_reg[k][2*W]}}, plo_reg[k]};
                end
            end
        end
    endgenerate

    // stage 4 numerators, picked by shape
    logic [NW-1:0] num_sel [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            num_sel[i] = m3_reg ? cof3_reg[i] : '0;
        end
        if (!m3_reg)
        begin
            num_sel[0] = {{(W+1){a3_reg[4][W-1]}}, a3_reg[4]};
            num_sel[1] = {NW{1'b0}} - {{(W+1){a3_reg[1][W-1]}}, a3_reg[1]};
            num_sel[3] = {NW{1'b0}} - {{(W+1){a3_reg[3][W-1]}}, a3_reg[3]};
            num_sel[4] = {{(W+1){a3_reg[0][W-1]}}, a3_reg[0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num4_reg <= num_sel;
        end
    end

    // stage 5 determinant: 3x3 expansion along row 0, or the 2x2 cofactor
    logic [NW-1:0] cof8_4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cof8_4_reg <= cof3_reg[8];
            if (m4_reg)
            begin
                det5_reg <= {t4_reg[0][TW-1], t4_reg[0]} +
                            {t4_reg[1][TW-1], t4_reg[1]} +
                            {t4_reg[2][TW-1], t4_reg[2]};
            end
            else
            begin
                det5_reg <= {{(W+2){cof8_4_reg[NW-1]}}, cof8_4_reg};
            end
        end
    end

    // word to the middle queue: status, numerators, determinant
    assign mid_wdata[DW+9*NW +: 2] = st5_reg;
    assign mid_wdata[DW-1:0]       = det5_reg;

    generate
        for (k = 0; k < 9; k++)
        begin : g_pack
            assign mid_wdata[DW + k*NW +: NW] = num5_reg[k];
        end
    endgenerate

endmodule

@@ sv/smi_back.sv @@
// smi_back: restoring division pipeline, one quotient bit per stage in
// nine lanes, then saturation; uses smi_pkg
`timescale 1ns / 1ps

module smi_back import smi_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic [2+9*(2*ELEM_WIDTH+1)+3*ELEM_WIDTH+2:0] mid_rdata,
    input  logic                                         mid_empty,
    output logic                                         mid_pop,
    output logic                                         out_push,
    input  logic                                         out_full,
    output logic [2+9*ELEM_WIDTH-1:0]                    out_wdata
);

    localparam int W   = ELEM_WIDTH;
    localparam int NW  = 2*W + 1;
    localparam int DW  = 3*W + 3;
    localparam int QB  = W + 1;
    localparam int NSH = NW + 2*FRAC_BITS;
    localparam int DSH = DW + QB;
    localparam int CW  = ((NSH > DSH) ? NSH : DSH) + 1;

    localparam logic [QB-1:0] POS_LIM = {2'b00, {(W-1){1'b1}}};
    localparam logic [QB-1:0] NEG_LIM = {2'b01, {(W-1){1'b0}}};
    localparam logic [W-1:0]  SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SAT_MIN = {1'b1, {(W-1){1'b0}}};

    logic en;

    // stage b0: magnitudes and signs
    logic          v0_reg;
    logic [NW-1:0] nabs_reg [9];
    logic          nneg_reg [9];
    logic [DW-1:0] dabs_reg;
    logic          dneg_reg;
    status_t       st0_reg;

    // division stages: index 0 is the range check, s holds s quotient bits
    logic          vd_reg  [QB+1];
    logic [DW-1:0] dd_reg  [QB+1];
    status_t       sd_reg  [QB+1];
    logic [CW-1:0] rem_reg [QB+1][9];
    logic [QB-1:0] q_reg   [QB+1][9];
    logic          big_reg [QB+1][9];
    logic          neg_reg [QB+1][9];

    // final saturated results
    logic          vf_reg;
    status_t       sf_reg;
    logic [W-1:0]  fin_reg [9];

    logic [DW-1:0] d_in;
    logic          d_neg;
    status_t       st_in;

    // whole back advances unless the finished word is held
    assign en       = ~(vf_reg & out_full);
    assign mid_pop  = en & ~mid_empty;
    assign out_push = vf_reg & ~out_full;

    assign d_in  = mid_rdata[DW-1:0];
    assign d_neg = d_in[DW-1];
    assign st_in = status_t'(mid_rdata[DW+9*NW +: 2]);

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            vf_reg <= 1'b0;
            for (int s = 0; s <= QB; s++)
            begin
                vd_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg    <= ~mid_empty;
            vd_reg[0] <= v0_reg;
            for (int s = 1; s <= QB; s++)
            begin
                vd_reg[s] <= vd_reg[s-1];
            end
            vf_reg <= vd_reg[QB];
        end
    end

    // determinant magnitude, singular check, shared stage carry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dabs_reg <= d_neg ? ({DW{1'b0}} - d_in) : d_in;
            dneg_reg <= d_neg;
            if (st_in == ST_OK && d_in == '0)
            begin
                st0_reg <= ST_SINGULAR;
            end
            else
            begin
                st0_reg <= st_in;
            end
            dd_reg[0] <= dabs_reg;
            sd_reg[0] <= st0_reg;
            for (int s = 1; s <= QB; s++)
            begin
                dd_reg[s] <= dd_reg[s-1];
                sd_reg[s] <= sd_reg[s-1];
            end
            sf_reg <= sd_reg[QB];
        end
    end

    genvar l, s;
    generate
        for (l = 0; l < 9; l++)
        begin : g_lane
            logic [NW-1:0] n_in;
            logic [CW-1:0] nsh;
            logic [CW-1:0] dlim;
            logic [QB-1:0] qneg;
            logic [W-1:0]  res;

            assign n_in = mid_rdata[DW + l*NW +: NW];
            assign nsh  = CW'(nabs_reg[l]) << (2*FRAC_BITS);
            assign dlim = CW'(dabs_reg) << QB;

            // numerator magnitude, then range check and remainder seed
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nabs_reg[l]   <= n_in[NW-1] ? ({NW{1'b0}} - n_in) : n_in;
                    nneg_reg[l]   <= n_in[NW-1];
                    rem_reg[0][l] <= nsh;
                    big_reg[0][l] <= (nsh >= dlim);
                    q_reg[0][l]   <= '0;
                    neg_reg[0][l] <= nneg_reg[l] ^ dneg_reg;
                end
            end

            // one quotient bit per stage, most significant first
            for (s = 1; s <= QB; s++)
            begin : g_step
                logic [CW-1:0] dsh;
                logic          ge;
                assign dsh = CW'(dd_reg[s-1]) << (QB - s);
                assign ge  = (rem_reg[s-1][l] >= dsh);

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[s][l] <= ge ? (rem_reg[s-1][l] - dsh) : rem_reg[s-1][l];
                        q_reg[s][l]   <= q_reg[s-1][l] | (QB'(ge) << (QB - s));
                        big_reg[s][l] <= big_reg[s-1][l];
                        neg_reg[s][l] <= neg_reg[s-1][l];
                    end
                end
            end

            // sign and saturation; errors give zero
            assign qneg = {QB{1'b0}} - q_reg[QB][l];

            always_comb
            begin
                if (sd_reg[QB] != ST_OK)
                begin
                    res = '0;
                end
                else if (neg_reg[QB][l])
                begin
                    res = (big_reg[QB][l] || q_reg[QB][l] > NEG_LIM) ? SAT_MIN
                                                                       : qneg[W-1:0];
                end
                else
                begin
                    res = (big_reg[QB][l] || q_reg[QB][l] > POS_LIM) ? SAT_MAX
                                                                       : q_reg[QB][l][W-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    fin_reg[l] <= res;
                end
            end

            assign out_wdata[l*W +: W] = fin_reg[l];
        end
    endgenerate

    assign out_wdata[9*W +: 2] = sf_reg;

endmodule

@@ sv/small_matrix_inverse.sv @@
// small_matrix_inverse: top level, front end, middle queue, divider back
// end and result queue; uses smi_pkg, smi_front, smi_fifo, smi_back
//
//   channel   direction  handshake           payload
//   input     in         push / full         row_count, col_count, a00..a22
//   result    out        empty / pop         status, b00..b22
//
// one matrix per cycle sustained unless a held result stalls the pipeline;
// the divider forms one quotient bit per stage over ELEM_WIDTH + 1 stages,
// after six front stages
// reset clears all valid bits and queue counts; no clearing pass
// a held result stalls the back end, the middle queue absorbs up to MID_DEPTH words,
// then full rises toward the input side
`timescale 1ns / 1ps

module small_matrix_inverse import smi_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   row_count,
    input  logic [1:0]                   col_count,
    input  logic signed [ELEM_WIDTH-1:0] a00,
    input  logic signed [ELEM_WIDTH-1:0] a01,
    input  logic signed [ELEM_WIDTH-1:0] a02,
    input  logic signed [ELEM_WIDTH-1:0] a10,
    input  logic signed [ELEM_WIDTH-1:0] a11,
    input  logic signed [ELEM_WIDTH-1:0] a12,
    input  logic signed [ELEM_WIDTH-1:0] a20,
    input  logic signed [ELEM_WIDTH-1:0] a21,
    input  logic signed [ELEM_WIDTH-1:0] a22,
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   status,
    output logic signed [ELEM_WIDTH-1:0] b00,
    output logic signed [ELEM_WIDTH-1:0] b01,
    output logic signed [ELEM_WIDTH-1:0] b02,
    output logic signed [ELEM_WIDTH-1:0] b10,
    output logic signed [ELEM_WIDTH-1:0] b11,
    output logic signed [ELEM_WIDTH-1:0] b12,
    output logic signed [ELEM_WIDTH-1:0] b20,
    output logic signed [ELEM_WIDTH-1:0] b21,
    output logic signed [ELEM_WIDTH-1:0] b22
);

    localparam int W  = ELEM_WIDTH;
    localparam int MW = 2 + 9*(2*W+1) + 3*W + 3;
    localparam int OW = 2 + 9*W;

    logic [W-1:0]  elem [9];
    logic          mid_push, mid_full, mid_pop, mid_empty;
    logic [MW-1:0] mid_wdata, mid_rdata;
    logic          out_push, out_full;
    logic [OW-1:0] out_wdata, out_rdata;

    assign elem[0] = a00;
    assign elem[1] = a01;
    assign elem[2] = a02;
    assign elem[3] = a10;
    assign elem[4] = a11;
    assign elem[5] = a12;
    assign elem[6] = a20;
    assign elem[7] = a21;
    assign elem[8] = a22;

    smi_front #(.ELEM_WIDTH(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .row_count (row_count),
        .col_count (col_count),
        .elem      (elem),
        .mid_push  (mid_push),
        .mid_full  (mid_full),
        .mid_wdata (mid_wdata)
    );

    smi_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    smi_back #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_rdata (mid_rdata),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_push  (out_push),
        .out_full  (out_full),
        .out_wdata (out_wdata)
    );

    smi_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    // result word fields
    assign status = out_rdata[9*W +: 2];
    assign b00    = out_rdata[0*W +: W];
    assign b01    = out_rdata[1*W +: W];
    assign b02    = out_rdata[2*W +: W];
    assign b10    = out_rdata[3*W +: W];
    assign b11    = out_rdata[4*W +: W];
    assign b12    = out_rdata[5*W +: W];
    assign b20    = out_rdata[6*W +: W];
    assign b21    = out_rdata[7*W +: W];
    assign b22    = out_rdata[8*W +: W];

endmodule

@@ sv/smi_checker.sv @@
// smi_checker: port-level checks on the small matrix inverse, attached
// by bind; uses smi_pkg
`timescale 1ns / 1ps

module smi_checker import smi_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [1:0]            status,
    input logic [ELEM_WIDTH-1:0] b00,
    input logic [ELEM_WIDTH-1:0] b01,
    input logic [ELEM_WIDTH-1:0] b02,
    input logic [ELEM_WIDTH-1:0] b10,
    input logic [ELEM_WIDTH-1:0] b11,
    input logic [ELEM_WIDTH-1:0] b12,
    input logic [ELEM_WIDTH-1:0] b20,
    input logic [ELEM_WIDTH-1:0] b21,
    input logic [ELEM_WIDTH-1:0] b22
);

    // no word is shown while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // an error status carries an all-zero matrix
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |->
            (b00 == '0 && b01 == '0 && b02 == '0 && b10 == '0 && b11 == '0 &&
             b12 == '0 && b20 == '0 && b21 == '0 && b22 == '0))
        else $error("nonzero result with error status");

    // a waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(b00) &&
                              $stable(b11) && $stable(b22)))
        else $error("waiting result changed");

endmodule

bind small_matrix_inverse smi_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_smi_checker (.*);

@@ test/smi_checker.sv @@
// smi_scoreboard: watches the input and result channels of small_matrix_inverse,
// predicts each inverse and compares it field by field; uses smi_pkg
`timescale 1ns / 1ps

module smi_scoreboard import smi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [1:0]         row_count,
    input  logic [1:0]         col_count,
    input  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
    input  logic               empty,
    input  logic               pop,
    input  logic [1:0]         status,
    input  logic signed [31:0] b00, b01, b02, b10, b11, b12, b20, b21, b22,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    typedef struct {
        status_t            st;
        logic signed [31:0] b [9];
    } inverse_t;

    inverse_t inv_q [$];

    // exact adjugate over determinant, truncated toward zero and saturated
    function automatic inverse_t invert(input logic [1:0] rows, input logic [1:0] cols,
                                        input logic signed [31:0] a [9]);
        inverse_t           res;
        logic signed [127:0] x [9];
        logic signed [127:0] num [9];
        logic signed [127:0] det;
        logic signed [127:0] quo;
        res.st = ST_OK;
        for (int i = 0; i < 9; i++)
        begin
            res.b[i] = '0;
            x[i] = a[i];
            num[i] = '0;
        end
        if (rows != cols || (rows != SHAPE_2X2 && rows != SHAPE_3X3))
        begin
            res.st = ST_SHAPE;
            return res;
        end
        if (rows == SHAPE_2X2)
        begin
            det = x[0] * x[4] - x[1] * x[3];
            num[0] = x[4];
            num[1] = -x[1];
            num[3] = -x[3];
            num[4] = x[0];
        end
        else
        begin
            for (int k = 0; k < 9; k++)
                num[k] = x[COF_P[k]] * x[COF_Q[k]] - x[COF_R[k]] * x[COF_S[k]];
            det = x[0] * num[0] + x[1] * num[3] + x[2] * num[6];
        end
        if (det == 0)
        begin
            res.st = ST_SINGULAR;
            return res;
        end
        for (int i = 0; i < 9; i++)
        begin
            if (rows == SHAPE_2X2 && (i % 3 == 2 || i / 3 == 2))
                continue;
            quo = (num[i] <<< (2 * FRAC_BITS_DEF)) / det;
            if (quo > 128'sd2147483647)
                res.b[i] = 32'sh7fffffff;
            else if (quo < -128'sd2147483648)
                res.b[i] = 32'sh80000000;
            else
                res.b[i] = quo[31:0];
        end
        return res;
    endfunction

    // record expected inverse on each accepted word, compare each popped word
    always @(posedge clk or negedge rst_n)
    begin
        inverse_t           want;
        logic signed [31:0] ins [9];
        logic signed [31:0] got [9];
        int                 nerr;
        if (!rst_n)
        begin
            errors  <= 0;
            checked <= 0;
            pending <= 0;
        end
        else
        begin
            nerr = 0;
            if (push && !full)
            begin
                ins = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
                inv_q.push_back(invert(row_count, col_count, ins));
            end
            if (pop && !empty)
            begin
                got = '{b00, b01, b02, b10, b11, b12, b20, b21, b22};
                if (inv_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected", $time);
                    nerr++;
                end
                else
                begin
                    want = inv_q.pop_front();
                    checked <= checked + 1;
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                        nerr++;
                    end
                    for (int i = 0; i < 9; i++)
                    begin
                        if (got[i] !== want.b[i])
                        begin
                            $display("%0t: b%0d%0d expected %h actual %h",
                                     $time, i / 3, i % 3, want.b[i], got[i]);
                            nerr++;
                        end
                    end
                end
            end
            errors  <= errors + nerr;
            pending <= inv_q.size();
        end
    end

endmodule

@@ test/tb.sv @@
// tb: clock, reset, matrix stimulus and result popping for small_matrix_inverse;
// depends on smi_pkg, small_matrix_inverse and smi_scoreboard
`timescale 1ns / 1ps

module tb;
    import smi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [1:0]         row_count;
    logic [1:0]         col_count;
    logic signed [31:0] m [9];
    logic               empty;
    logic               pop;
    logic [1:0]         status;
    logic signed [31:0] b [9];
    int                 errors;
    int                 pending;
    int                 checked;
    int                 cycles;
    int                 popped;
    int                 stall_cnt;
    bit                 stall_done;

    small_matrix_inverse u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .row_count(row_count), .col_count(col_count),
        .a00(m[0]), .a01(m[1]), .a02(m[2]), .a10(m[3]), .a11(m[4]),
        .a12(m[5]), .a20(m[6]), .a21(m[7]), .a22(m[8]),
        .empty(empty), .pop(pop), .status(status),
        .b00(b[0]), .b01(b[1]), .b02(b[2]), .b10(b[3]), .b11(b[4]),
        .b12(b[5]), .b20(b[6]), .b21(b[7]), .b22(b[8])
    );

    smi_scoreboard u_chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .row_count(row_count), .col_count(col_count),
        .a00(m[0]), .a01(m[1]), .a02(m[2]), .a10(m[3]), .a11(m[4]),
        .a12(m[5]), .a20(m[6]), .a21(m[7]), .a22(m[8]),
        .empty(empty), .pop(pop), .status(status),
        .b00(b[0]), .b01(b[1]), .b02(b[2]), .b10(b[3]), .b11(b[4]),
        .b12(b[5]), .b20(b[6]), .b21(b[7]), .b22(b[8]),
        .errors(errors), .pending(pending), .checked(checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("small_matrix_inverse verification failed");
                $finish;
            end
        end
    end

    // gap length: mostly none, some short, a few long
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 93)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // random element: full range, small fixed point, an extreme or a small whole number
    function automatic logic signed [31:0] rand_elem();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return $urandom;
        if (k < 6)
            return $signed($urandom_range(0, 262144)) - 32'sd131072;
        if (k < 7)
        begin
            case ($urandom_range(0, 4))
                0: return 32'sh80000000;
                1: return 32'sh7fffffff;
                2: return 32'sd0;
                3: return 32'sd1;
                default: return -32'sd1;
            endcase
        end
        return ($signed($urandom_range(0, 16)) - 32'sd8) <<< 16;
    endfunction

    // receiver: random pop gaps, one long hold after 120 pops, steady pops from 400 to 480
    initial
    begin
        int hold;
        pop = 1'b0;
        popped = 0;
        stall_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                popped++;
            if (!stall_done && popped >= 120)
            begin
                stall_done = 1'b1;
                pop <= 1'b0;
                for (stall_cnt = 0; stall_cnt < 300; stall_cnt++)
                    @(posedge clk);
                pop <= 1'b1;
            end
            else if (popped > 400 && popped < 480)
                pop <= 1'b1;
            else
            begin
                hold = gap_len();
                if (hold == 0)
                    pop <= 1'b1;
                else
                begin
                    pop <= 1'b0;
                    repeat (hold - 1) @(posedge clk);
                end
            end
        end
    end

    // offer one word and wait until it is taken
    task automatic send_matrix(input logic [1:0] r, input logic [1:0] c,
                               input logic signed [31:0] v [9]);
        int g;
        push <= 1'b1;
        row_count <= r;
        col_count <= c;
        for (int i = 0; i < 9; i++)
            m[i] <= v[i];
        @(posedge clk);
        while (full)
            @(posedge clk);
        g = gap_len();
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_diag(input logic [1:0] r, input logic signed [31:0] d);
        logic signed [31:0] v [9];
        for (int i = 0; i < 9; i++)
            v[i] = (i % 4 == 0) ? d : 32'sd0;
        send_matrix(r, r, v);
    endtask

    task automatic send_fill(input logic [1:0] r, input logic [1:0] c,
                             input logic signed [31:0] e);
        logic signed [31:0] v [9];
        for (int i = 0; i < 9; i++)
            v[i] = e;
        send_matrix(r, c, v);
    endtask

    // stimulus
    initial
    begin
        logic signed [31:0] v [9];
        logic [1:0]         r;
        int                 k;
        rst_n = 1'b0;
        push = 1'b0;
        row_count = '0;
        col_count = '0;
        for (int i = 0; i < 9; i++)
            m[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, scaling, saturation both ways
        send_diag(SHAPE_2X2, 32'sh00010000);
        send_diag(SHAPE_3X3, 32'sh00010000);
        send_diag(SHAPE_3X3, 32'sh00020000);
        send_diag(SHAPE_2X2, 32'sd1);
        send_diag(SHAPE_2X2, -32'sd1);
        send_diag(SHAPE_3X3, 32'sh80000000);
        send_diag(SHAPE_3X3, 32'sh7fffffff);
        send_diag(SHAPE_2X2, 32'sh80000000);
        // unsupported shapes
        send_diag(2'd0, 32'sh00010000);
        send_diag(2'd1, 32'sh00010000);
        send_fill(SHAPE_2X2, SHAPE_3X3, 32'sh00010000);
        send_fill(SHAPE_3X3, SHAPE_2X2, 32'sh00010000);
        send_fill(2'd1, 2'd0, -32'sd1);
        // singular: equal elements, zero matrix
        send_fill(SHAPE_3X3, SHAPE_3X3, 32'sh7fffffff);
        send_fill(SHAPE_2X2, SHAPE_2X2, 32'sh80000000);
        send_fill(SHAPE_3X3, SHAPE_3X3, 32'sd0);
        // extremes off the diagonal
        v = '{32'sh80000000, 32'sh7fffffff, 32'sd1, -32'sd1, 32'sh80000000,
              32'sh7fffffff, 32'sd0, 32'sh00010000, 32'sh80000000};
        send_matrix(SHAPE_3X3, SHAPE_3X3, v);
        send_matrix(SHAPE_2X2, SHAPE_2X2, v);
        v = '{32'sh7fffffff, 32'sh80000000, 32'sd5, 32'sh80000000, 32'sh7fffffff,
              -32'sd7, 32'sd3, -32'sd2, 32'sd1};
        send_matrix(SHAPE_3X3, SHAPE_3X3, v);
        send_matrix(SHAPE_2X2, SHAPE_2X2, v);

        // random: mostly valid squares, some singular, some bad shapes
        repeat (630)
        begin
            for (int i = 0; i < 9; i++)
                v[i] = rand_elem();
            k = $urandom_range(0, 99);
            r = ($urandom_range(0, 1) == 0) ? SHAPE_2X2 : SHAPE_3X3;
            if (k < 10)
            begin
                // duplicate a row so the determinant is zero
                for (int c = 0; c < 3; c++)
                    v[3 + c] = v[c];
                send_matrix(r, r, v);
            end
            else if (k < 20)
                send_matrix(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), v);
            else
                send_matrix(r, r, v);
        end
        push <= 1'b0;

        // drain, then let the pipeline settle
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("matrices checked: %0d, covering 2x2 and 3x3 inverses,", checked);
        $display("bad shapes, singular cases, saturation and a long result stall");
        if (errors == 0 && pending == 0)
            $display("small_matrix_inverse verification clean");
        else
            $display("small_matrix_inverse verification failed");
        $finish;
    end

endmodule
